@@ rtl/oah_pkg.sv @@
`default_nettype none
package oah_pkg;

    localparam int TABLE_SLOTS  = 13;
    localparam int KEY_BITS     = 16;
    localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
    localparam int SUM_BITS     = SLOT_BITS + 1;
    localparam int IDX_BITS     = 4;
    localparam int CNT_BITS     = 4;

    // key / TABLE_SLOTS as (key * HASH_RECIP) >> HASH_SHIFT, exact for every key
    localparam int HASH_RECIP   = 80660;
    localparam int HASH_SHIFT   = 20;
    localparam int PROD_BITS    = KEY_BITS + 17;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_ZERO_KEY = 2'd2,
        STAT_DONE     = 2'd3
    } status_t;

endpackage
`default_nettype wire

@@ rtl/oah_mod_add.sv @@
`default_nettype none
// (a + b) mod TABLE_SLOTS for a + b < 2 * TABLE_SLOTS
module oah_mod_add
    import oah_pkg::*;
(
    input  wire logic [SUM_BITS-1:0]  a_in,
    input  wire logic [SUM_BITS-1:0]  b_in,
    output logic      [SLOT_BITS-1:0] sum_mod
);

    logic [SUM_BITS:0] sum;
    logic [SUM_BITS:0] diff;

    assign sum  = {1'b0, a_in} + {1'b0, b_in};
    assign diff = sum - (SUM_BITS+1)'(TABLE_SLOTS);

    always_comb begin
        if (sum >= (SUM_BITS+1)'(TABLE_SLOTS)) begin
            sum_mod = diff[SLOT_BITS-1:0];
        end else begin
            sum_mod = sum[SLOT_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

@@ rtl/open_addressing_hash_insert.sv @@
// Accept to result: insert runs the hash, then a table read and a check per slot probed;
// read runs one table read and check; clear, zero key and unused command go straight out.
// One word at a time: the hash does a reciprocal multiply step and then a remainder step,
// then each probe does a table read step and a check step on the shared modular adder.
// Next word is taken once the result is in the output register.
// Reset (aresetn low, synchronous) empties the table at once through per-slot valid bits.
`default_nettype none
module open_addressing_hash_insert
    import oah_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_cmd,
    input  wire logic [KEY_BITS-1:0]  s_key_value,
    input  wire logic [IDX_BITS-1:0]  s_slot_index,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_status,
    output logic [IDX_BITS-1:0]       m_placed_slot,
    output logic [CNT_BITS-1:0]       m_probe_count,
    output logic [KEY_BITS-1:0]       m_read_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_HOME,
        ST_PROBE,
        ST_CHECK,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [IDX_BITS-1:0]     idx_reg, idx_next;
    logic                    in_range_reg, in_range_next;
    logic [SLOT_BITS-1:0]    pos_reg, pos_next;
    logic [SLOT_BITS-1:0]    a_reg, a_next;
    logic [SLOT_BITS-1:0]    d_reg, d_next;
    logic [SLOT_BITS-1:0]    quot_reg, quot_next;
    logic [TABLE_SLOTS-1:0]  valid_reg, valid_next;
    logic                    mode_reg, mode_next;

    status_t                 res_status_reg, res_status_next;
    logic [IDX_BITS-1:0]     res_slot_reg, res_slot_next;
    logic [CNT_BITS-1:0]     res_count_reg, res_count_next;
    logic [KEY_BITS-1:0]     res_data_reg, res_data_next;

    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [IDX_BITS-1:0]     m_slot_reg, m_slot_next;
    logic [CNT_BITS-1:0]     m_count_reg, m_count_next;
    logic [KEY_BITS-1:0]     m_data_reg, m_data_next;

    // table memory, one port
    logic [KEY_BITS-1:0]     mem [TABLE_SLOTS];
    logic [KEY_BITS-1:0]     rdata_reg;
    logic                    vq_reg;
    logic                    mem_we;

    logic [SUM_BITS-1:0]     ua;
    logic [SUM_BITS-1:0]     ub;
    logic [SLOT_BITS-1:0]    unit_out;

    logic [PROD_BITS-1:0]    hash_prod;
    logic [2*SLOT_BITS-1:0]  quot_x13;

    oah_mod_add u_mod_add (
        .a_in    (ua),
        .b_in    (ub),
        .sum_mod (unit_out)
    );

    // key mod 13: quotient by reciprocal multiply, then key - 13q on the low bits only
    assign hash_prod = PROD_BITS'(key_reg) * PROD_BITS'(HASH_RECIP);
    assign quot_x13  = (2*SLOT_BITS)'(quot_reg) * (2*SLOT_BITS)'(TABLE_SLOTS);

    always_comb begin
        case (state_reg)
            ST_PROBE: begin
                ua = SUM_BITS'(d_reg);
                ub = SUM_BITS'(2);
            end
            default: begin
                ua = SUM_BITS'(pos_reg);
                ub = SUM_BITS'(d_reg);
            end
        endcase
    end

    assign mem_we  = (state_reg == ST_CHECK) && (cmd_reg == CMD_INSERT) && !vq_reg;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        in_range_next   = in_range_reg;
        pos_next        = pos_reg;
        a_next          = a_reg;
        d_next          = d_reg;
        quot_next       = quot_reg;
        valid_next      = valid_reg;
        mode_next       = cfg_wr_en ? cfg_wr_data : mode_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;
        res_data_next   = res_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_count_next    = m_count_reg;
        m_data_next     = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next        = cmd_t'(s_cmd);
                    res_status_next = STAT_DONE;
                    res_slot_next   = '0;
                    res_count_next  = '0;
                    res_data_next   = '0;
                    case (cmd_t'(s_cmd))
                        CMD_INSERT: begin
                            key_next = s_key_value;
                            if (s_key_value == '0) begin
                                res_status_next = STAT_ZERO_KEY;
                                state_next      = ST_OUT;
                            end else begin
                                state_next = ST_HASH;
                            end
                        end
                        CMD_CLEAR: begin
                            valid_next = '0;
                            state_next = ST_OUT;
                        end
                        CMD_READ: begin
                            idx_next      = s_slot_index;
                            in_range_next = (s_slot_index < TABLE_SLOTS);
                            pos_next      = (s_slot_index < TABLE_SLOTS) ?
                                            SLOT_BITS'(s_slot_index) : '0;
                            state_next    = ST_PROBE;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_HASH: begin
                quot_next  = hash_prod[HASH_SHIFT+SLOT_BITS-1:HASH_SHIFT];
                state_next = ST_HOME;
            end
            ST_HOME: begin
                pos_next   = key_reg[SLOT_BITS-1:0] - quot_x13[SLOT_BITS-1:0];
                a_next     = '0;
                d_next     = SLOT_BITS'(1);
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                // quadratic: step to next offset grows by 2a+1
                if (cmd_reg == CMD_INSERT && a_reg != '0 && mode_reg) begin
                    d_next = unit_out;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (cmd_reg == CMD_READ) begin
                    res_status_next = STAT_DONE;
                    res_slot_next   = idx_reg;
                    res_count_next  = '0;
                    res_data_next   = (in_range_reg && vq_reg) ? rdata_reg : '0;
                    state_next      = ST_OUT;
                end else if (!vq_reg) begin
                    valid_next[pos_reg] = 1'b1;
                    res_status_next     = STAT_INSERTED;
                    res_slot_next       = IDX_BITS'(pos_reg);
                    res_count_next      = CNT_BITS'(a_reg);
                    res_data_next       = '0;
                    state_next          = ST_OUT;
                end else if (a_reg == SLOT_BITS'(TABLE_SLOTS - 1)) begin
                    res_status_next = STAT_FULL;
                    res_slot_next   = '0;
                    res_count_next  = CNT_BITS'(TABLE_SLOTS - 1);
                    res_data_next   = '0;
                    state_next      = ST_OUT;
                end else begin
                    a_next     = a_reg + 1'b1;
                    pos_next   = unit_out;
                    state_next = ST_PROBE;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    m_count_next  = res_count_reg;
                    m_data_next   = res_data_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        in_range_reg   <= in_range_next;
        pos_reg        <= pos_next;
        a_reg          <= a_next;
        d_reg          <= d_next;
        quot_reg       <= quot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_count_reg  <= res_count_next;
        res_data_reg   <= res_data_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_count_reg    <= m_count_next;
        m_data_reg     <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[pos_reg] <= key_reg;
        end
        rdata_reg <= mem[pos_reg];
        vq_reg    <= valid_reg[pos_reg];
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_placed_slot = m_slot_reg;
    assign m_probe_count = m_count_reg;
    assign m_read_data   = m_data_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("block took a word while busy");

    a_probe_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE && cmd_reg == CMD_INSERT) |-> (pos_reg < TABLE_SLOTS))
        else $error("probe slot outside table");

    a_write_empty_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !valid_reg[pos_reg])
        else $error("insert overwrote an occupied slot");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STAT_FULL) |->
            (m_count_reg == CNT_BITS'(TABLE_SLOTS - 1)))
        else $error("table full reported with short probe count");

endmodule
`default_nettype wire

@@ tb/tb_open_addressing_hash_insert.sv @@
module tb_open_addressing_hash_insert
    import oah_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RESET_CYCLES = 6;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 212;
    localparam int HOLD_START   = 6000;
    localparam int HOLD_LEN     = 400;
    localparam int CALM_START   = 7000;
    localparam int CALM_END     = 10000;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 60;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        status_t             status;
        logic [IDX_BITS-1:0] placed_slot;
        logic [CNT_BITS-1:0] probe_count;
        logic [KEY_BITS-1:0] read_data;
    } reply_t;

    typedef struct packed {
        bit                  is_cfg;
        bit                  cfg_val;
        logic [1:0]          cmd;
        logic [KEY_BITS-1:0] key;
        logic [IDX_BITS-1:0] idx;
        bit                  typed;
        reply_t              want;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_cmd;
    logic [KEY_BITS-1:0] s_key_value;
    logic [IDX_BITS-1:0] s_slot_index;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_status;
    logic [IDX_BITS-1:0] m_placed_slot;
    logic [CNT_BITS-1:0] m_probe_count;
    logic [KEY_BITS-1:0] m_read_data;

    // side info traveling with the word on the input channel
    bit                  row_typed;
    reply_t              row_want;

    logic [KEY_BITS-1:0] shadow_slots [TABLE_SLOTS];
    bit                  shadow_quadratic = 1'b0;
    reply_t              pending_replies [$];

    int cycle_count = 0;
    int idle_run    = 0;
    int fault_count = 0;
    int words_in    = 0;
    int mode_words [2];
    int placed_cnt  = 0;
    int full_cnt    = 0;
    int zero_cnt    = 0;
    int done_cnt    = 0;
    int max_probes  = 0;

    open_addressing_hash_insert dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_key_value  (s_key_value),
        .s_slot_index (s_slot_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_placed_slot(m_placed_slot),
        .m_probe_count(m_probe_count),
        .m_read_data  (m_read_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit take_break();
        if (cycle_count >= CALM_START && cycle_count < CALM_END) return 1'b0;
        return $urandom_range(0, 99) < 36;
    endfunction

    // Hash table behavior; updates the shadow table.
    function automatic reply_t hash_table_op(logic [1:0] cmd, logic [KEY_BITS-1:0] key,
                                             logic [IDX_BITS-1:0] idx);
        reply_t r;
        int     home;
        int     pos;
        bit     placed;
        r = '0;
        r.status = STAT_DONE;
        case (cmd)
            CMD_INSERT: begin
                if (key == '0) begin
                    r.status = STAT_ZERO_KEY;
                end else begin
                    home   = int'(key) % TABLE_SLOTS;
                    placed = 1'b0;
                    // offset 0 is the home slot
                    for (int a = 0; a < TABLE_SLOTS && !placed; a++) begin
                        pos = (home + (shadow_quadratic ? a * a : a)) % TABLE_SLOTS;
                        if (shadow_slots[pos] == '0) begin
                            shadow_slots[pos] = key;
                            r.status      = STAT_INSERTED;
                            r.placed_slot = IDX_BITS'(pos);
                            r.probe_count = CNT_BITS'(a);
                            placed        = 1'b1;
                        end
                    end
                    if (!placed) begin
                        r.status      = STAT_FULL;
                        r.probe_count = CNT_BITS'(TABLE_SLOTS - 1);
                    end
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < TABLE_SLOTS; i++) shadow_slots[i] = '0;
            end
            CMD_READ: begin
                r.placed_slot = idx;
                if (idx < TABLE_SLOTS) r.read_data = shadow_slots[idx];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic row_t word_row(logic [1:0] c, logic [KEY_BITS-1:0] k,
                                      logic [IDX_BITS-1:0] i);
        row_t r;
        r = '0;
        r.cmd = c;
        r.key = k;
        r.idx = i;
        return r;
    endfunction

    function automatic row_t checked_row(logic [1:0] c, logic [KEY_BITS-1:0] k,
                                         logic [IDX_BITS-1:0] i, status_t st,
                                         logic [IDX_BITS-1:0] sl, logic [CNT_BITS-1:0] pr,
                                         logic [KEY_BITS-1:0] d);
        row_t r;
        r = word_row(c, k, i);
        r.typed            = 1'b1;
        r.want.status      = st;
        r.want.placed_slot = sl;
        r.want.probe_count = pr;
        r.want.read_data   = d;
        return r;
    endfunction

    function automatic row_t mode_row(bit v);
        row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    task automatic offer_word(input logic [1:0] cmd, input logic [KEY_BITS-1:0] key,
                              input logic [IDX_BITS-1:0] idx, input bit typed,
                              input reply_t want);
        while (take_break()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_key_value  <= key;
        s_slot_index <= idx;
        row_typed    <= typed;
        row_want     <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drain the block, then write the probe mode while it is idle.
    task automatic set_probe_mode(input bit v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en        <= 1'b0;
        shadow_quadratic  = v;
    endtask

    // Sender and sequencing
    initial begin
        row_t                plan [$];
        reply_t              none;
        logic [1:0]          cmd;
        logic [KEY_BITS-1:0] key;
        logic [IDX_BITS-1:0] idx;
        int                  pick;

        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        s_valid      = 1'b0;
        s_cmd        = CMD_INSERT;
        s_key_value  = '0;
        s_slot_index = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        none         = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) shadow_slots[i] = '0;

        plan = '{
            checked_row(CMD_READ,   16'h0000, 4'd0,  STAT_DONE,     4'd0,  4'd0,  16'h0000),
            checked_row(CMD_READ,   16'hFFFF, 4'd15, STAT_DONE,     4'd15, 4'd0,  16'h0000),
            checked_row(CMD_INSERT, 16'h0000, 4'd15, STAT_ZERO_KEY, 4'd0,  4'd0,  16'h0000),
            checked_row(CMD_INSERT, 16'd13,   4'd0,  STAT_INSERTED, 4'd0,  4'd0,  16'h0000),
            word_row(CMD_INSERT, 16'd26,   4'd0),
            word_row(CMD_INSERT, 16'hFFFF, 4'd0),
            word_row(CMD_INSERT, 16'd13,   4'd0),   // duplicate key
            word_row(CMD_READ,   16'h0000, 4'd1),
            word_row(CMD_READ,   16'h0000, 4'd12),
            checked_row(CMD_UNUSED, 16'hFFFF, 4'd15, STAT_DONE,     4'd0,  4'd0,  16'h0000),
            checked_row(CMD_CLEAR,  16'hFFFF, 4'd15, STAT_DONE,     4'd0,  4'd0,  16'h0000),
            checked_row(CMD_READ,   16'h0000, 4'd3,  STAT_DONE,     4'd3,  4'd0,  16'h0000),
            mode_row(1'b1),
            // quadratic path from slot 0 reaches only 7 slots
            word_row(CMD_INSERT, 16'd13, 4'd0),
            word_row(CMD_INSERT, 16'd26, 4'd0),
            word_row(CMD_INSERT, 16'd39, 4'd0),
            word_row(CMD_INSERT, 16'd52, 4'd0),
            word_row(CMD_INSERT, 16'd65, 4'd0),
            word_row(CMD_INSERT, 16'd78, 4'd0),
            word_row(CMD_INSERT, 16'd91, 4'd0),
            checked_row(CMD_INSERT, 16'd104,  4'd0,  STAT_FULL,     4'd0,  4'd12, 16'h0000),
            word_row(CMD_READ,   16'h0000, 4'd4),
            word_row(CMD_READ,   16'h0000, 4'd9),
            mode_row(1'b0),
            word_row(CMD_INSERT, 16'd1,    4'd0)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                set_probe_mode(plan[n].cfg_val);
            end else begin
                offer_word(plan[n].cmd, plan[n].key, plan[n].idx, plan[n].typed,
                           plan[n].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            set_probe_mode(ph[0]);
            for (int w = 0; w < PHASE_WORDS; w++) begin
                pick = $urandom_range(0, 99);
                key  = KEY_BITS'($urandom);
                idx  = IDX_BITS'($urandom_range(0, 15));
                if (pick < 3) begin
                    cmd = CMD_CLEAR;
                end else if (pick < 5) begin
                    cmd = CMD_UNUSED;
                end else if (pick < 8) begin
                    cmd = CMD_INSERT;
                    key = '0;
                end else if (pick < 60) begin
                    cmd = CMD_INSERT;
                    // half the keys crowd a few home slots to force long probe runs
                    if ($urandom_range(0, 1))
                        key = KEY_BITS'($urandom_range(0, 5040) * 13 + $urandom_range(0, 2));
                end else begin
                    cmd = CMD_READ;
                    if ($urandom_range(0, 9) != 0) idx = IDX_BITS'($urandom_range(0, 12));
                end
                offer_word(cmd, key, idx, 1'b0, none);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d words (%0d linear, %0d quadratic): %0d placed, max probes %0d,",
                 words_in, mode_words[0], mode_words[1], placed_cnt, max_probes);
        $display("  %0d table full, %0d zero key, %0d clear/read/unused; %0d faults",
                 full_cnt, zero_cnt, done_cnt, fault_count);
        if (fault_count == 0) begin
            $display("tb_open_addressing_hash_insert passed");
        end else begin
            $display("tb_open_addressing_hash_insert failed");
        end
        $finish;
    end

    // Receiver, with one long hold-off so the block backs up
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (cycle_count == HOLD_START) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end
            m_ready <= aresetn && !take_break();
        end
    end

    // Predict on input accept, check on output accept
    always @(posedge aclk) begin : scoreboard
        reply_t predicted;
        reply_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = hash_table_op(s_cmd, s_key_value, s_slot_index);
                pending_replies.push_back(row_typed ? row_want : predicted);
                words_in++;
                mode_words[shadow_quadratic]++;
            end
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    if (fault_count < MAX_REPORTS)
                        $display("unexpected word: status %0d slot %0d probes %0d data %h",
                                 m_status, m_placed_slot, m_probe_count, m_read_data);
                    fault_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_status !== want.status || m_placed_slot !== want.placed_slot ||
                        m_probe_count !== want.probe_count ||
                        m_read_data !== want.read_data) begin
                        if (fault_count < MAX_REPORTS) begin
                            $write("mismatch @%0d: exp st %0d sl %0d pr %0d d %h,",
                                   cycle_count, want.status, want.placed_slot,
                                   want.probe_count, want.read_data);
                            $display(" got st %0d sl %0d pr %0d d %h",
                                     m_status, m_placed_slot, m_probe_count, m_read_data);
                        end
                        fault_count++;
                    end
                    case (want.status)
                        STAT_INSERTED: placed_cnt++;
                        STAT_FULL:     full_cnt++;
                        STAT_ZERO_KEY: zero_cnt++;
                        default:       done_cnt++;
                    endcase
                    if (want.status == STAT_INSERTED && int'(want.probe_count) > max_probes)
                        max_probes = int'(want.probe_count);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("tb_open_addressing_hash_insert failed");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

endmodule

@@ filelist.f @@
rtl/oah_pkg.sv
rtl/oah_mod_add.sv
rtl/open_addressing_hash_insert.sv
tb/tb_open_addressing_hash_insert.sv
